// ----- src/mlpiir4_pkg.sv -----
// Shared constants, types and helper functions of the multichannel low-pass IIR.
`default_nettype none

package mlpiir4_pkg;

    localparam int NUM_CHANNELS = 12;
    localparam int CH_W         = 4;
    localparam int SAMPLE_W     = 32;
    localparam int GAIN_W       = 32;
    localparam int HIST_W       = 48;
    localparam int FRAC_W       = 24;
    localparam int TAPS         = 4;
    localparam int PIPE_STAGES  = 4;

    localparam int MEM_DEPTH = (NUM_CHANNELS < (1 << CH_W)) ? NUM_CHANNELS : (1 << CH_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Q2.30 feedback taps, index 0 weights the oldest output
    localparam logic signed [31:0] FB_COEF [TAPS] = '{
        -32'sd59876032, 32'sd389090799, -32'sd1106441381, 32'sd1402956591
    };

    typedef logic [TAPS-1:0][HIST_W-1:0] t_taps;

    typedef struct packed {
        t_taps xh;
        t_taps yh;
    } t_hist_row;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_hist_row         row;
    } t_wr_req;

    typedef struct packed {
        logic [PIPE_STAGES-1:0]           vld;
        logic [PIPE_STAGES-1:0][CH_W-1:0] ch;
    } t_pipe_stat;

    function automatic logic ch_in_range(input logic [CH_W-1:0] ch);
        return int'(ch) < NUM_CHANNELS;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [55:0] v);
        if (v > 56'sd140737488355327) begin
            return 48'sh7FFF_FFFF_FFFF;
        end else if (v < -56'sd140737488355328) begin
            return 48'sh8000_0000_0000;
        end
        return v[47:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -48'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- src/mlpiir4_hist_mem.sv -----
// Per-channel history memory with registered read and reset-cleared row valid bits.
`default_nettype none

module mlpiir4_hist_mem
    import mlpiir4_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    input  wire t_wr_req           i_wr,
    output t_hist_row              o_rd_row
);

    t_hist_row              r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]   r_row_valid;
    t_hist_row              r_rd_row;
    logic                   r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_hit    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_row_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_row_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.row;
        end
        if (i_rd_en) begin
            r_rd_row <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_hit ? r_rd_row : '0;

endmodule

`default_nettype wire

// ----- src/mlpiir4_pipe.sv -----
// Four-stage filter datapath: input scaling, feedback MAC, sum, saturation and write-back.
`default_nettype none

module mlpiir4_pipe
    import mlpiir4_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_acc,
    input  wire logic [CH_W-1:0]            i_channel,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_value,
    input  wire logic [GAIN_W-1:0]          i_inverse_gain,
    input  wire t_hist_row                  i_rd_row,
    output t_pipe_stat                      o_stat,
    output t_wr_req                         o_wr,
    output logic                            o_res_valid,
    output logic [CH_W-1:0]                 o_res_channel,
    output logic signed [SAMPLE_W-1:0]      o_res_value
);

    logic [PIPE_STAGES-1:0]           r_vld;
    logic [PIPE_STAGES-1:0][CH_W-1:0] r_ch;
    logic [PIPE_STAGES-1:0]           r_inr;

    logic signed [64:0] n_prod;
    logic signed [63:0] r1_prod;

    logic signed [63:0] n_x4_rnd;
    logic [HIST_W-1:0]  n_x4;
    logic signed [55:0] n_ph [TAPS];
    logic signed [56:0] n_pl [TAPS];
    t_hist_row          r2_row;
    logic [HIST_W-1:0]  r2_x4;
    logic signed [55:0] r2_ph [TAPS];
    logic signed [56:0] r2_pl [TAPS];

    logic signed [57:0] n_a;
    logic signed [58:0] n_b;
    logic [HIST_W-1:0]  n_ff;
    t_taps              n_xrow;
    logic signed [57:0] r3_a;
    logic signed [58:0] r3_b;
    logic [HIST_W-1:0]  r3_ff;
    t_taps              r3_xrow;
    t_taps              r3_yh;

    logic signed [83:0] n_w;
    logic signed [53:0] n_fb;
    logic signed [48:0] n_ff128;
    logic signed [53:0] r4_fb;
    logic signed [47:0] r4_ff;
    logic signed [48:0] r4_ff128;
    t_taps              r4_xrow;
    t_taps              r4_yh;

    logic signed [55:0] n_z;
    logic signed [55:0] n_zq;
    logic signed [47:0] n_y;
    logic signed [31:0] n_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], i_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ch  <= {r_ch[PIPE_STAGES-2:0], i_channel};
            r_inr <= {r_inr[PIPE_STAGES-2:0], ch_in_range(i_channel)};
        end
    end

    assign n_prod = i_sample_value * $signed({1'b0, i_inverse_gain});

    always_comb begin
        n_x4_rnd = r1_prod + 64'sd8388608;
        n_x4     = {{8{n_x4_rnd[63]}}, n_x4_rnd[63:FRAC_W]};
        for (int k = 0; k < TAPS; k++) begin
            n_ph[k] = $signed(i_rd_row.yh[k][HIST_W-1:FRAC_W]) * FB_COEF[k];
            n_pl[k] = $signed({1'b0, i_rd_row.yh[k][FRAC_W-1:0]}) * FB_COEF[k];
        end
    end

    always_comb begin
        n_a = '0;
        n_b = '0;
        for (int k = 0; k < TAPS; k++) begin
            n_a = n_a + 58'(r2_ph[k]);
            n_b = n_b + 59'(r2_pl[k]);
        end
        n_ff = r2_row.xh[0] + r2_x4 + ((r2_row.xh[1] + r2_row.xh[3]) << 2)
             + (r2_row.xh[2] << 2) + (r2_row.xh[2] << 1);
        n_xrow = {r2_x4, r2_row.xh[3], r2_row.xh[2], r2_row.xh[1]};
    end

    always_comb begin
        n_w     = {{2{r3_a[57]}}, r3_a, 24'b0} + {{25{r3_b[58]}}, r3_b} + 84'sd536870912;
        n_fb    = n_w[83:30];
        n_ff128 = {r3_ff[HIST_W-1], r3_ff} + 49'sd128;
    end

    always_comb begin
        n_z  = {{8{r4_ff[47]}}, r4_ff} + {{2{r4_fb[53]}}, r4_fb};
        n_zq = {{7{r4_ff128[48]}}, r4_ff128} + {{2{r4_fb[53]}}, r4_fb};
        n_y  = sat48(n_z);
        n_q  = sat32(n_zq[55:8]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod  <= n_prod[63:0];
            r2_row   <= i_rd_row;
            r2_x4    <= n_x4;
            r2_ph    <= n_ph;
            r2_pl    <= n_pl;
            r3_a     <= n_a;
            r3_b     <= n_b;
            r3_ff    <= n_ff;
            r3_xrow  <= n_xrow;
            r3_yh    <= r2_row.yh;
            r4_fb    <= n_fb;
            r4_ff    <= $signed(r3_ff);
            r4_ff128 <= n_ff128;
            r4_xrow  <= r3_xrow;
            r4_yh    <= r3_yh;
        end
    end

    assign o_wr.en     = i_en && r_vld[PIPE_STAGES-1] && r_inr[PIPE_STAGES-1];
    assign o_wr.addr   = r_ch[PIPE_STAGES-1][ADDR_W-1:0];
    assign o_wr.row.xh = r4_xrow;
    assign o_wr.row.yh = {n_y, r4_yh[3], r4_yh[2], r4_yh[1]};

    assign o_res_valid   = r_vld[PIPE_STAGES-1];
    assign o_res_channel = r_ch[PIPE_STAGES-1];
    assign o_res_value   = r_inr[PIPE_STAGES-1] ? n_q : '0;

    assign o_stat.vld = r_vld;
    assign o_stat.ch  = r_ch;

endmodule

`default_nettype wire

// ----- src/multichannel_lowpass_iir4.sv -----
// Top level of the twelve-channel fourth-order Butterworth low-pass IIR filter.
//
//  channel   direction  handshake               payload
//  input     in         i_valid / o_ready       i_channel, i_sample_value
//  result    out        o_valid / i_ready       o_channel_out, o_filtered_value
//  config    in         i_cfg_valid / o_cfg_ready  i_inverse_gain
//
// Items of different channels enter one per cycle unless the result register stalls; a result
// passes the four pipeline stages, then the result register. An item whose channel is still in
// those stages waits: the read-modify-write loop through the history memory.
// Synchronous reset clears the row valid bits, so all history reads as zero at once.
// A stalled result register freezes the whole pipeline and holds o_ready low.

`default_nettype none

module multichannel_lowpass_iir4
    import mlpiir4_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [CH_W-1:0]            i_channel,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [CH_W-1:0]                 o_channel_out,
    output logic signed [SAMPLE_W-1:0]      o_filtered_value,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [GAIN_W-1:0]          i_inverse_gain
);

    logic [GAIN_W-1:0]          r_inverse_gain;
    logic                       r_out_valid;
    logic [CH_W-1:0]            r_out_channel;
    logic signed [SAMPLE_W-1:0] r_out_value;

    logic       en;
    logic       hazard;
    logic       acc;
    t_hist_row  rd_row;
    t_wr_req    wr;
    t_pipe_stat stat;
    logic                       res_valid;
    logic [CH_W-1:0]            res_channel;
    logic signed [SAMPLE_W-1:0] res_value;

    assign en = !r_out_valid || i_ready;

    always_comb begin
        hazard = 1'b0;
        for (int s = 0; s < PIPE_STAGES; s++) begin
            hazard = hazard || (stat.vld[s] && (stat.ch[s] == i_channel));
        end
    end

    assign o_ready     = en && !hazard;
    assign acc         = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse_gain <= '0;
        end else if (i_cfg_valid) begin
            r_inverse_gain <= i_inverse_gain;
        end
    end

    mlpiir4_hist_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (acc && ch_in_range(i_channel)),
        .i_rd_addr (i_channel[ADDR_W-1:0]),
        .i_wr      (wr),
        .o_rd_row  (rd_row)
    );

    mlpiir4_pipe u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_acc          (acc),
        .i_channel      (i_channel),
        .i_sample_value (i_sample_value),
        .i_inverse_gain (r_inverse_gain),
        .i_rd_row       (rd_row),
        .o_stat         (stat),
        .o_wr           (wr),
        .o_res_valid    (res_valid),
        .o_res_channel  (res_channel),
        .o_res_value    (res_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_channel <= res_channel;
            r_out_value   <= res_value;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_channel_out    = r_out_channel;
    assign o_filtered_value = r_out_value;

endmodule

`default_nettype wire

// ----- src/mlpiir4_checker.sv -----
// Port-level assertions for the multichannel low-pass IIR and their bind to the top level.
`default_nettype none

module mlpiir4_checker
    import mlpiir4_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_valid,
    input wire logic                       o_ready,
    input wire logic [CH_W-1:0]            i_channel,
    input wire logic                       o_valid,
    input wire logic                       i_ready,
    input wire logic [CH_W-1:0]            o_channel_out,
    input wire logic signed [SAMPLE_W-1:0] o_filtered_value
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_channel_out) && $stable(o_filtered_value))
        else $error("result beat changed while stalled");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while result register stalled");

    a_same_channel_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !(i_valid && o_ready && (i_channel == $past(i_channel))))
        else $error("same channel accepted on consecutive cycles");

    a_bad_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (int'(o_channel_out) >= NUM_CHANNELS) |-> (o_filtered_value == '0))
        else $error("out-of-range channel gave nonzero result");

endmodule

bind multichannel_lowpass_iir4 mlpiir4_checker u_chk (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the twelve-channel low-pass IIR: predicts each result and compares.
`timescale 1ns / 1ps

module tb_top;
    import mlpiir4_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_PAUSE     = 10;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PHASE_ITEMS     = 80;

    localparam logic [GAIN_W-1:0] NOMINAL_GAIN = 32'h06AE_B8F1;

    localparam logic signed [31:0] FEEDBACK_Q30 [TAPS] = '{
        -32'sd59876032, 32'sd389090799, -32'sd1106441381, 32'sd1402956591
    };

    localparam logic signed [95:0] Y48_HI = 96'sd140737488355327;
    localparam logic signed [95:0] Y48_LO = -96'sd140737488355328;
    localparam logic signed [95:0] Q32_HI = 96'sd2147483647;
    localparam logic signed [95:0] Q32_LO = -96'sd2147483648;

    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_HALF, RX_RARELY} t_rx_mode;

    typedef struct packed {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] value;
    } t_filt_result;

    class lowpass_tracker;
        logic [GAIN_W-1:0]        inv_gain;
        logic signed [HIST_W-1:0] x_hist [NUM_CHANNELS][TAPS];
        logic signed [HIST_W-1:0] y_hist [NUM_CHANNELS][TAPS];
        t_filt_result             expected_filtered [$];
        int                       mismatches;

        function new();
            inv_gain   = '0;
            mismatches = 0;
            foreach (x_hist[c, k]) begin
                x_hist[c][k] = '0;
                y_hist[c][k] = '0;
            end
        endfunction

        function int pending();
            return expected_filtered.size();
        endfunction

        function void note_sample(input logic [CH_W-1:0] ch,
                                  input logic signed [SAMPLE_W-1:0] smp);
            t_filt_result       r;
            logic signed [71:0] s_ext;
            logic signed [71:0] g_ext;
            logic signed [71:0] scaled;
            logic signed [95:0] xw [TAPS];
            logic signed [95:0] yw [TAPS];
            logic signed [95:0] cw;
            logic signed [95:0] fb_sum;
            logic signed [95:0] acc;
            logic signed [95:0] out_q;
            int                 k;
            r.ch    = ch;
            r.value = '0;
            if (int'(ch) < NUM_CHANNELS) begin
                s_ext  = 72'(smp);
                g_ext  = {40'd0, inv_gain};
                scaled = (s_ext * g_ext + 72'sd8388608) >>> 24;
                fb_sum = '0;
                for (k = 0; k < TAPS; k++) begin
                    xw[k]  = 96'(x_hist[ch][k]);
                    yw[k]  = 96'(y_hist[ch][k]);
                    cw     = 96'(FEEDBACK_Q30[k]);
                    fb_sum = fb_sum + cw * yw[k];
                end
                acc = xw[0] + 96'(scaled) + 96'sd4 * (xw[1] + xw[3]) + 96'sd6 * xw[2]
                    + ((fb_sum + 96'sd536870912) >>> 30);
                if (acc > Y48_HI) begin
                    acc = Y48_HI;
                end else if (acc < Y48_LO) begin
                    acc = Y48_LO;
                end
                for (k = 0; k < TAPS - 1; k++) begin
                    x_hist[ch][k] = x_hist[ch][k+1];
                    y_hist[ch][k] = y_hist[ch][k+1];
                end
                x_hist[ch][TAPS-1] = scaled[HIST_W-1:0];
                y_hist[ch][TAPS-1] = acc[HIST_W-1:0];
                out_q = (acc + 96'sd128) >>> 8;
                if (out_q > Q32_HI) begin
                    out_q = Q32_HI;
                end else if (out_q < Q32_LO) begin
                    out_q = Q32_LO;
                end
                r.value = out_q[SAMPLE_W-1:0];
            end
            expected_filtered.push_back(r);
        endfunction

        function void check_filtered(input logic [CH_W-1:0] ch,
                                     input logic signed [SAMPLE_W-1:0] value);
            t_filt_result r;
            if (expected_filtered.size() == 0) begin
                $error("unexpected result beat: channel_out %0d filtered_value %0d", ch, value);
                mismatches++;
                return;
            end
            r = expected_filtered.pop_front();
            if (ch !== r.ch) begin
                $error("channel_out: expected %0d, actual %0d", r.ch, ch);
                mismatches++;
            end
            if (value !== r.value) begin
                $error("filtered_value: expected %0d, actual %0d", r.value, value);
                mismatches++;
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [CH_W-1:0]            i_channel;
    logic signed [SAMPLE_W-1:0] i_sample_value;
    logic                       o_valid;
    logic                       i_ready;
    logic [CH_W-1:0]            o_channel_out;
    logic signed [SAMPLE_W-1:0] o_filtered_value;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [GAIN_W-1:0]          i_inverse_gain;

    lowpass_tracker tracker;
    bit             hold_off_req = 1'b0;
    int             idle_cycles  = 0;

    multichannel_lowpass_iir4 u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_channel        (i_channel),
        .i_sample_value   (i_sample_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_channel_out    (o_channel_out),
        .o_filtered_value (o_filtered_value),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_inverse_gain   (i_inverse_gain)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                tracker.inv_gain = i_inverse_gain;
            end
            if (i_valid && o_ready) begin
                tracker.note_sample(i_channel, i_sample_value);
            end
            if (o_valid && i_ready) begin
                tracker.check_filtered(o_channel_out, o_filtered_value);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side: stall pattern of its own, plus one long hold-off on request
    initial begin
        t_rx_mode mode;
        int       seg_left;
        seg_left = 0;
        mode     = RX_ALWAYS;
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (mode)
                    RX_ALWAYS: i_ready <= 1'b1;
                    RX_MOSTLY: i_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:   i_ready <= 1'($urandom_range(0, 1));
                    default:   i_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] smp);
        i_valid        <= 1'b1;
        i_channel      <= ch;
        i_sample_value <= smp;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] gain);
        i_cfg_valid    <= 1'b1;
        i_inverse_gain <= gain;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic run_items(input int target);
        int                         sent;
        int                         burst;
        int                         pick;
        int                         level [16];
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] smp;
        sent = 0;
        foreach (level[c]) level[c] = 0;
        while (sent < target) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if ($urandom_range(0, 9) == 0) begin
                    ch = CH_W'($urandom_range(NUM_CHANNELS, 15));
                end else begin
                    ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
                end
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    smp = $urandom;
                end else begin
                    if (pick == 3) begin
                        level[ch] = int'($urandom_range(0, 8388608)) - 4194304;
                    end
                    smp = level[ch] + int'($urandom_range(0, 8191)) - 4096;
                end
                send_item(ch, smp);
                if (int'(ch) < NUM_CHANNELS) begin
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [GAIN_W-1:0] phase_gain [6];
        tracker = new();
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_channel      <= '0;
        i_sample_value <= '0;
        i_cfg_valid    <= 1'b0;
        i_inverse_gain <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // gain still at its reset value
        send_item(4'd0, 32'sh7FFF_FFFF);
        send_item(4'd15, 32'sh8000_0000);
        wait_drained();

        write_gain(32'hFFFF_FFFF);
        send_item(4'd0, 32'sh7FFF_FFFF);
        send_item(4'd1, 32'sh8000_0000);
        send_item(4'd2, 32'sh0000_0000);
        send_item(4'd3, 32'shFFFF_FFFF);
        send_item(4'd4, 32'sh0000_0001);
        send_item(4'd11, 32'sh7FFF_FFFF);
        send_item(4'd12, 32'sh1234_5678);
        send_item(4'd15, 32'sh8000_0000);
        repeat (6) send_item(4'd0, 32'sh7FFF_FFFF);
        repeat (6) send_item(4'd1, 32'sh8000_0000);
        wait_drained();

        phase_gain = '{NOMINAL_GAIN, $urandom, 32'h0000_0001, 32'h8000_0000,
                       32'hFFFF_FFFF, NOMINAL_GAIN};
        foreach (phase_gain[p]) begin
            write_gain(phase_gain[p]);
            if (p == 0) begin
                hold_off_req = 1'b1;
            end
            run_items(PHASE_ITEMS);
            wait_drained();
        end

        if (tracker.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/mlpiir4_pkg.sv
src/mlpiir4_hist_mem.sv
src/mlpiir4_pipe.sv
src/multichannel_lowpass_iir4.sv
src/mlpiir4_checker.sv
tb/sv/tb_top.sv
